/* src/xrf_pkg.sv */
// Package for the XMODEM receiver sequencer: state type, op and send codes,
// register reset values, the state-to-code mapping and a saturating increment. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xrf_pkg;

    localparam int OpW     = 3;
    localparam int CodeW   = 2;
    localparam int SeqW    = 8;
    localparam int StCodeW = 4;
    localparam int CntW    = 16;
    localparam int InDataW = 8;
    localparam int OutDataW = 24;

    localparam logic [OpW-1:0] OP_TICK  = 3'd0;
    localparam logic [OpW-1:0] OP_DATA  = 3'd1;
    localparam logic [OpW-1:0] OP_CAN   = 3'd2;
    localparam logic [OpW-1:0] OP_EOT   = 3'd3;
    localparam logic [OpW-1:0] OP_ETB   = 3'd4;

    localparam logic [CodeW-1:0] TX_NONE = 2'd0;
    localparam logic [CodeW-1:0] TX_C    = 2'd1;
    localparam logic [CodeW-1:0] TX_ACK  = 2'd2;
    localparam logic [CodeW-1:0] TX_NAK  = 2'd3;

    localparam logic [CntW-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [CntW-1:0] CNT_MAX       = 16'hFFFF;
    localparam logic [SeqW-1:0] SEQ_RESET     = 8'd1;

    localparam logic [StCodeW-1:0] CODE_SEND_C        = 4'd0;
    localparam logic [StCodeW-1:0] CODE_C_WAIT        = 4'd1;
    localparam logic [StCodeW-1:0] CODE_SEND_ACK      = 4'd2;
    localparam logic [StCodeW-1:0] CODE_ACK_WAIT      = 4'd3;
    localparam logic [StCodeW-1:0] CODE_SEND_NAK      = 4'd4;
    localparam logic [StCodeW-1:0] CODE_NAK_WAIT      = 4'd5;
    localparam logic [StCodeW-1:0] CODE_SEND_EOT_ACK  = 4'd6;
    localparam logic [StCodeW-1:0] CODE_EOT_ACK_WAIT  = 4'd7;
    localparam logic [StCodeW-1:0] CODE_SEND_FINAL    = 4'd8;
    localparam logic [StCodeW-1:0] CODE_DONE          = 4'd9;
    localparam logic [StCodeW-1:0] CODE_ERROR         = 4'd10;

    typedef enum logic [10:0] {
        ST_SEND_C       = 11'b000_0000_0001,
        ST_C_WAIT       = 11'b000_0000_0010,
        ST_SEND_ACK     = 11'b000_0000_0100,
        ST_ACK_WAIT     = 11'b000_0000_1000,
        ST_SEND_NAK     = 11'b000_0001_0000,
        ST_NAK_WAIT     = 11'b000_0010_0000,
        ST_SEND_EOT_ACK = 11'b000_0100_0000,
        ST_EOT_ACK_WAIT = 11'b000_1000_0000,
        ST_SEND_FINAL   = 11'b001_0000_0000,
        ST_DONE         = 11'b010_0000_0000,
        ST_ERROR        = 11'b100_0000_0000
    } rx_state_t;

    function automatic logic [StCodeW-1:0] state_code(input rx_state_t st);
        logic [StCodeW-1:0] c;
        case (st)
            ST_SEND_C:       c = CODE_SEND_C;
            ST_C_WAIT:       c = CODE_C_WAIT;
            ST_SEND_ACK:     c = CODE_SEND_ACK;
            ST_ACK_WAIT:     c = CODE_ACK_WAIT;
            ST_SEND_NAK:     c = CODE_SEND_NAK;
            ST_NAK_WAIT:     c = CODE_NAK_WAIT;
            ST_SEND_EOT_ACK: c = CODE_SEND_EOT_ACK;
            ST_EOT_ACK_WAIT: c = CODE_EOT_ACK_WAIT;
            ST_SEND_FINAL:   c = CODE_SEND_FINAL;
            ST_DONE:         c = CODE_DONE;
            ST_ERROR:        c = CODE_ERROR;
            default:         c = CODE_ERROR;
        endcase
        return c;
    endfunction

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

/* src/xmodem_receiver_fsm_top.sv */
// XMODEM receiver sequencer: input register, state update and a
// result register. Depends on xrf_pkg.
// Each request waits in the input register; its result is held in the result register.
// Throughput: one request per cycle, limited only by output back-pressure.
// The result register decouples the sides, so a new request is taken while a
// result still waits. Reset (aresetn low, synchronous) empties both registers,
// sets the send-C state, expected number 1, counters 0 and timeout 1000.
`timescale 1ns / 1ps
`default_nettype none

module xmodem_receiver_fsm_top
    import xrf_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [CntW-1:0]      cfg_data,
    input  wire                 s_tvalid,
    output logic                s_tready,
    // [0] packet_valid, [7:1] zero
    input  wire [InDataW-1:0]   s_tdata,
    // [2:0] op
    input  wire [OpW-1:0]       s_tuser,
    output logic                m_tvalid,
    input  wire                 m_tready,
    // [1:0] send_code, [2] packet_accepted, [10:3] expected_number,
    // [14:11] rx_state, [15] done_res, [16] failed, [23:17] zero
    output logic [OutDataW-1:0] m_tdata
);

    logic                in_valid_reg;
    logic [OpW-1:0]      in_op_reg;
    logic                in_pv_reg;
    logic                out_valid_reg;
    logic [OutDataW-1:0] out_data_reg;
    logic [CntW-1:0]     timeout_reg;
    rx_state_t           state_reg, state_next;
    logic [SeqW-1:0]     seq_reg, seq_next;
    logic [CntW-1:0]     c_cnt_reg, c_cnt_next;
    logic [CntW-1:0]     ack_cnt_reg, ack_cnt_next;
    logic [CntW-1:0]     nak_cnt_reg, nak_cnt_next;
    logic [CodeW-1:0]    code;
    logic                accepted;
    logic                advance;
    logic                wait_state;
    logic [StCodeW-1:0]  st_code;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        state_next   = state_reg;
        seq_next     = seq_reg;
        c_cnt_next   = c_cnt_reg;
        ack_cnt_next = ack_cnt_reg;
        nak_cnt_next = nak_cnt_reg;
        code         = TX_NONE;
        accepted     = 1'b0;
        wait_state   = (state_reg == ST_C_WAIT) || (state_reg == ST_ACK_WAIT) ||
                       (state_reg == ST_NAK_WAIT);
        if (state_reg != ST_DONE && state_reg != ST_ERROR) begin
            case (in_op_reg)
                OP_TICK: begin
                    c_cnt_next   = sat_inc(c_cnt_reg);
                    ack_cnt_next = sat_inc(ack_cnt_reg);
                    nak_cnt_next = sat_inc(nak_cnt_reg);
                    case (state_reg)
                        ST_SEND_C: begin
                            state_next = ST_C_WAIT;
                            c_cnt_next = '0;
                            code       = TX_C;
                        end
                        ST_C_WAIT: begin
                            if (c_cnt_next >= timeout_reg) begin
                                c_cnt_next = '0;
                                code       = TX_C;
                            end
                        end
                        ST_SEND_ACK: begin
                            state_next   = ST_ACK_WAIT;
                            ack_cnt_next = '0;
                            code         = TX_ACK;
                        end
                        ST_ACK_WAIT, ST_EOT_ACK_WAIT: begin
                            if (ack_cnt_next >= timeout_reg) begin
                                ack_cnt_next = '0;
                                code         = TX_ACK;
                            end
                        end
                        ST_SEND_NAK: begin
                            state_next   = ST_NAK_WAIT;
                            nak_cnt_next = '0;
                            code         = TX_NAK;
                        end
                        ST_NAK_WAIT: begin
                            if (nak_cnt_next >= timeout_reg) begin
                                nak_cnt_next = '0;
                                code         = TX_NAK;
                            end
                        end
                        ST_SEND_EOT_ACK: begin
                            state_next   = ST_EOT_ACK_WAIT;
                            ack_cnt_next = '0;
                            code         = TX_ACK;
                        end
                        ST_SEND_FINAL: begin
                            state_next   = ST_DONE;
                            ack_cnt_next = '0;
                            code         = TX_ACK;
                        end
                        default: begin
                        end
                    endcase
                end
                OP_DATA: begin
                    if (!in_pv_reg) begin
                        state_next = ST_SEND_NAK;
                    end else if (wait_state) begin
                        state_next = ST_SEND_ACK;
                        seq_next   = seq_reg + 8'd1;
                        accepted   = 1'b1;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                OP_CAN: begin
                    state_next = ST_SEND_C;
                end
                OP_EOT: begin
                    if (state_reg == ST_ACK_WAIT || state_reg == ST_NAK_WAIT) begin
                        state_next = ST_SEND_EOT_ACK;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                OP_ETB: begin
                    if (state_reg == ST_EOT_ACK_WAIT) begin
                        state_next = ST_SEND_FINAL;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                default: begin
                end
            endcase
        end
        st_code = state_code(state_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
            state_reg     <= ST_SEND_C;
            seq_reg       <= SEQ_RESET;
            c_cnt_reg     <= '0;
            ack_cnt_reg   <= '0;
            nak_cnt_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                seq_reg       <= seq_next;
                c_cnt_reg     <= c_cnt_next;
                ack_cnt_reg   <= ack_cnt_next;
                nak_cnt_reg   <= nak_cnt_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg <= s_tuser;
            in_pv_reg <= s_tdata[0];
        end
        if (advance) begin
            out_data_reg <= {7'd0,
                             (state_next == ST_ERROR),
                             (state_next == ST_DONE),
                             st_code,
                             seq_next,
                             accepted,
                             code};
        end
    end

endmodule

`default_nettype wire
